@@ rtl/homing_velocity_steer_top_defines.svh @@
// Assertion macros shared by the homing velocity steer RTL
`ifndef HOMING_VELOCITY_STEER_TOP_DEFINES_SVH
`define HOMING_VELOCITY_STEER_TOP_DEFINES_SVH

// checked only outside reset
`define HVS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// checked during reset as well
`define HVS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) else $error("assertion failed");

`endif

@@ rtl/hvs_pkg.sv @@
// Shared widths, register codes and carried types for the homing velocity steer
package hvs_pkg;
   localparam int CoordWidth = 24;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int SqWidth    = 2 * DiffWidth + 1;
   localparam int AccWidth   = SqWidth + 1;
   localparam int RootWidth  = DiffWidth + 1;
   localparam int SpeedWidth = 14;
   localparam int TurnWidth  = 16;
   localparam int TurnShift  = 15;
   localparam int NumWidth   = DiffWidth + SpeedWidth;
   localparam int QuoWidth   = SpeedWidth;
   localparam int ProdWidth  = DiffWidth + TurnWidth + 1;
   localparam int SumWidth   = ProdWidth - TurnShift + 1;
   localparam int ReqDataWidth = ((6 * CoordWidth + 7) / 8) * 8;
   localparam int RspDataWidth = ((2 * CoordWidth + 7) / 8) * 8;

   localparam logic [SpeedWidth-1:0] SpeedReset = SpeedWidth'(2560);
   localparam logic [TurnWidth-1:0]  TurnReset  = TurnWidth'(8192);

   typedef enum logic [0:0] {
      REG_TARGET_SPEED = 1'b0,
      REG_TURN_RATE    = 1'b1
   } reg_index_type;

   // travels alongside the length computation
   typedef struct packed {
      logic                         sx;
      logic                         sy;
      logic signed [CoordWidth-1:0] vx;
      logic signed [CoordWidth-1:0] vy;
   } carry_type;
endpackage

@@ rtl/homing_velocity_steer_top.sv @@
// Throughput: one transaction per cycle; square root and divide are fully
// pipelined, one bit per stage. The whole pipe stalls only while the output
// register holds a result that is not taken.
// Reset (synchronous, active high) empties the pipe and loads target_speed 2560
// and turn_rate 8192.
`include "homing_velocity_steer_top_defines.svh"

module homing_velocity_steer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // target_x, target_y, pos_x, pos_y, vel_x, vel_y
   input  logic [hvs_pkg::ReqDataWidth-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // new_vel_x, new_vel_y
   output logic [hvs_pkg::RspDataWidth-1:0]      rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [2:0]                            csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   localparam int CW = hvs_pkg::CoordWidth;

   logic [hvs_pkg::SpeedWidth-1:0] speed_ff;
   logic [hvs_pkg::TurnWidth-1:0]  turn_ff;
   hvs_pkg::reg_index_type reg_sel;
   logic csr_write, pipe_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = hvs_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= hvs_pkg::SpeedReset;
         turn_ff  <= hvs_pkg::TurnReset;
      end else if (csr_write) begin
         unique case (reg_sel)
            hvs_pkg::REG_TARGET_SPEED: speed_ff <= csr_pwdata[hvs_pkg::SpeedWidth-1:0];
            hvs_pkg::REG_TURN_RATE:    turn_ff  <= csr_pwdata[hvs_pkg::TurnWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         hvs_pkg::REG_TARGET_SPEED: csr_prdata = 32'(speed_ff);
         hvs_pkg::REG_TURN_RATE:    csr_prdata = 32'(turn_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   logic f_valid, s_valid, d_valid, dzero;
   logic [hvs_pkg::SqWidth-1:0] sum_sq;
   logic [hvs_pkg::NumWidth-1:0] f_nx, f_ny, s_nx, s_ny;
   logic [hvs_pkg::RootWidth-1:0] root;
   logic [hvs_pkg::QuoWidth-1:0] qx, qy;
   hvs_pkg::carry_type f_c, s_c, d_c;
   logic signed [CW-1:0] new_x, new_y;

   hvs_front u_front (
      .clock(clock), .reset(reset), .advance(pipe_en),
      .in_valid(req_tvalid && req_tready),
      .tx(req_tdata[CW-1:0]),      .ty(req_tdata[2*CW-1:CW]),
      .px(req_tdata[3*CW-1:2*CW]), .py(req_tdata[4*CW-1:3*CW]),
      .vx(req_tdata[5*CW-1:4*CW]), .vy(req_tdata[6*CW-1:5*CW]),
      .speed(speed_ff),
      .out_valid(f_valid), .sum_sq(sum_sq), .num_x(f_nx), .num_y(f_ny), .carry(f_c)
   );

   hvs_sqrt u_sqrt (
      .clock(clock), .reset(reset), .advance(pipe_en), .in_valid(f_valid),
      .sum_sq(sum_sq), .num_x_i(f_nx), .num_y_i(f_ny), .carry_i(f_c),
      .out_valid(s_valid), .root(root), .num_x_o(s_nx), .num_y_o(s_ny), .carry_o(s_c)
   );

   hvs_div u_div (
      .clock(clock), .reset(reset), .advance(pipe_en), .in_valid(s_valid),
      .root_len(root), .num_x(s_nx), .num_y(s_ny), .carry_i(s_c),
      .out_valid(d_valid), .dist_zero(dzero), .quo_x(qx), .quo_y(qy), .carry_o(d_c)
   );

   hvs_blend u_blend (
      .clock(clock), .reset(reset), .advance(pipe_en), .in_valid(d_valid),
      .dist_zero(dzero), .quo_x(qx), .quo_y(qy), .carry(d_c), .turn(turn_ff),
      .out_valid(rsp_tvalid), .new_x(new_x), .new_y(new_y)
   );

   assign rsp_tdata = hvs_pkg::RspDataWidth'({new_y, new_x});

   `HVS_ASSERT(a_stall_blocks_intake, rsp_tvalid && !rsp_tready |-> !req_tready)
   `HVS_ASSERT(a_stall_holds_result, !pipe_en |=> $stable(rsp_tdata))
   `HVS_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_tvalid)
endmodule

@@ rtl/hvs_front.sv @@
// Difference vector, magnitudes, squares and speed products (four stages)
module hvs_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   in_valid,
   input  logic signed [hvs_pkg::CoordWidth-1:0]  tx,
   input  logic signed [hvs_pkg::CoordWidth-1:0]  ty,
   input  logic signed [hvs_pkg::CoordWidth-1:0]  px,
   input  logic signed [hvs_pkg::CoordWidth-1:0]  py,
   input  logic signed [hvs_pkg::CoordWidth-1:0]  vx,
   input  logic signed [hvs_pkg::CoordWidth-1:0]  vy,
   input  logic [hvs_pkg::SpeedWidth-1:0]         speed,
   output logic                                   out_valid,
   output logic [hvs_pkg::SqWidth-1:0]            sum_sq,
   output logic [hvs_pkg::NumWidth-1:0]           num_x,
   output logic [hvs_pkg::NumWidth-1:0]           num_y,
   output hvs_pkg::carry_type                     carry
);
   localparam int DW = hvs_pkg::DiffWidth;

   logic [3:0] valid_ff, valid_in;
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [DW-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [2*DW-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [hvs_pkg::NumWidth-1:0] nx3_ff, nx3_in, ny3_ff, ny3_in, nx4_ff, ny4_ff;
   logic [hvs_pkg::SqWidth-1:0] sum_ff, sum_in;
   hvs_pkg::carry_type c1_ff, c1_in, c2_ff, c3_ff, c4_ff;

   always_comb begin
      valid_in = {valid_ff[2:0], in_valid};
      dx_in = DW'(tx) - DW'(px);
      dy_in = DW'(ty) - DW'(py);
      c1_in = '{sx: 1'b0, sy: 1'b0, vx: vx, vy: vy};
      // magnitude of the most negative difference still fits unsigned
      ax_in = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
      ay_in = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);
      sqx_in = (2*DW)'(ax_ff) * (2*DW)'(ax_ff);
      sqy_in = (2*DW)'(ay_ff) * (2*DW)'(ay_ff);
      nx3_in = hvs_pkg::NumWidth'(ax_ff) * hvs_pkg::NumWidth'(speed);
      ny3_in = hvs_pkg::NumWidth'(ay_ff) * hvs_pkg::NumWidth'(speed);
      sum_in = hvs_pkg::SqWidth'(sqx_ff) + hvs_pkg::SqWidth'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         c1_ff  <= c1_in;
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         c2_ff  <= '{sx: dx_ff[DW-1], sy: dy_ff[DW-1], vx: c1_ff.vx, vy: c1_ff.vy};
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         nx3_ff <= nx3_in;
         ny3_ff <= ny3_in;
         c3_ff  <= c2_ff;
         sum_ff <= sum_in;
         nx4_ff <= nx3_ff;
         ny4_ff <= ny3_ff;
         c4_ff  <= c3_ff;
      end
   end

   assign out_valid = valid_ff[3];
   assign sum_sq    = sum_ff;
   assign num_x     = nx4_ff;
   assign num_y     = ny4_ff;
   assign carry     = c4_ff;
endmodule

@@ rtl/hvs_sqrt.sv @@
// Pipelined floor square root, one result bit per stage
module hvs_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [hvs_pkg::SqWidth-1:0]       sum_sq,
   input  logic [hvs_pkg::NumWidth-1:0]      num_x_i,
   input  logic [hvs_pkg::NumWidth-1:0]      num_y_i,
   input  hvs_pkg::carry_type                carry_i,
   output logic                              out_valid,
   output logic [hvs_pkg::RootWidth-1:0]     root,
   output logic [hvs_pkg::NumWidth-1:0]      num_x_o,
   output logic [hvs_pkg::NumWidth-1:0]      num_y_o,
   output hvs_pkg::carry_type                carry_o
);
   localparam int RW = hvs_pkg::RootWidth;
   localparam int AW = hvs_pkg::AccWidth;

   logic [RW-1:0] valid_ff;
   logic [AW-1:0] n_ff [RW];
   logic [AW-1:0] res_ff [RW];
   logic [hvs_pkg::NumWidth-1:0] nx_ff [RW];
   logic [hvs_pkg::NumWidth-1:0] ny_ff [RW];
   hvs_pkg::carry_type c_ff [RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      localparam logic [AW-1:0] BitVal = AW'(1) << (2 * (RW - 1 - i));
      logic [AW-1:0] n_prev, res_prev, trial, n_in, res_in;
      logic v_prev;
      logic [hvs_pkg::NumWidth-1:0] nx_prev, ny_prev;
      hvs_pkg::carry_type c_prev;

      if (i == 0) begin : g_first
         assign n_prev   = AW'(sum_sq);
         assign res_prev = '0;
         assign v_prev   = in_valid;
         assign nx_prev  = num_x_i;
         assign ny_prev  = num_y_i;
         assign c_prev   = carry_i;
      end else begin : g_rest
         assign n_prev   = n_ff[i-1];
         assign res_prev = res_ff[i-1];
         assign v_prev   = valid_ff[i-1];
         assign nx_prev  = nx_ff[i-1];
         assign ny_prev  = ny_ff[i-1];
         assign c_prev   = c_ff[i-1];
      end

      always_comb begin
         trial = res_prev + BitVal;
         if (n_prev >= trial) begin
            n_in   = n_prev - trial;
            res_in = (res_prev >> 1) + BitVal;
         end else begin
            n_in   = n_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= v_prev;
         end
         if (advance) begin
            n_ff[i]   <= n_in;
            res_ff[i] <= res_in;
            nx_ff[i]  <= nx_prev;
            ny_ff[i]  <= ny_prev;
            c_ff[i]   <= c_prev;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign root      = res_ff[RW-1][RW-1:0];
   assign num_x_o   = nx_ff[RW-1];
   assign num_y_o   = ny_ff[RW-1];
   assign carry_o   = c_ff[RW-1];
endmodule

@@ rtl/hvs_div.sv @@
// Pipelined restoring divide of both speed products by the length
module hvs_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [hvs_pkg::RootWidth-1:0]     root_len,
   input  logic [hvs_pkg::NumWidth-1:0]      num_x,
   input  logic [hvs_pkg::NumWidth-1:0]      num_y,
   input  hvs_pkg::carry_type                carry_i,
   output logic                              out_valid,
   output logic                              dist_zero,
   output logic [hvs_pkg::QuoWidth-1:0]      quo_x,
   output logic [hvs_pkg::QuoWidth-1:0]      quo_y,
   output hvs_pkg::carry_type                carry_o
);
   localparam int QW = hvs_pkg::QuoWidth;
   localparam int RemW = hvs_pkg::NumWidth + 1;

   // length >= each axis magnitude, so every quotient fits in the speed width
   logic [QW-1:0] valid_ff;
   logic [RemW-1:0] rx_ff [QW];
   logic [RemW-1:0] ry_ff [QW];
   logic [QW-1:0] qx_ff [QW];
   logic [QW-1:0] qy_ff [QW];
   logic [hvs_pkg::RootWidth-1:0] d_ff [QW];
   hvs_pkg::carry_type c_ff [QW];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      localparam int Shift = QW - 1 - j;
      logic [RemW-1:0] rx_prev, ry_prev, dsh, rx_in, ry_in;
      logic [QW-1:0] qx_prev, qy_prev, qx_in, qy_in;
      logic [hvs_pkg::RootWidth-1:0] d_prev;
      logic v_prev;
      hvs_pkg::carry_type c_prev;

      if (j == 0) begin : g_first
         assign rx_prev = RemW'(num_x);
         assign ry_prev = RemW'(num_y);
         assign qx_prev = '0;
         assign qy_prev = '0;
         assign d_prev  = root_len;
         assign v_prev  = in_valid;
         assign c_prev  = carry_i;
      end else begin : g_rest
         assign rx_prev = rx_ff[j-1];
         assign ry_prev = ry_ff[j-1];
         assign qx_prev = qx_ff[j-1];
         assign qy_prev = qy_ff[j-1];
         assign d_prev  = d_ff[j-1];
         assign v_prev  = valid_ff[j-1];
         assign c_prev  = c_ff[j-1];
      end

      always_comb begin
         dsh   = RemW'(d_prev) << Shift;
         rx_in = rx_prev;
         ry_in = ry_prev;
         qx_in = qx_prev;
         qy_in = qy_prev;
         if (rx_prev >= dsh) begin
            rx_in = rx_prev - dsh;
            qx_in[Shift] = 1'b1;
         end
         if (ry_prev >= dsh) begin
            ry_in = ry_prev - dsh;
            qy_in[Shift] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= v_prev;
         end
         if (advance) begin
            rx_ff[j] <= rx_in;
            ry_ff[j] <= ry_in;
            qx_ff[j] <= qx_in;
            qy_ff[j] <= qy_in;
            d_ff[j]  <= d_prev;
            c_ff[j]  <= c_prev;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign dist_zero = (d_ff[QW-1] == '0);
   assign quo_x     = qx_ff[QW-1];
   assign quo_y     = qy_ff[QW-1];
   assign carry_o   = c_ff[QW-1];
endmodule

@@ rtl/hvs_blend.sv @@
// Signed wanted velocity, blend by turn rate, floor shift and saturation
module hvs_blend (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   in_valid,
   input  logic                                   dist_zero,
   input  logic [hvs_pkg::QuoWidth-1:0]           quo_x,
   input  logic [hvs_pkg::QuoWidth-1:0]           quo_y,
   input  hvs_pkg::carry_type                     carry,
   input  logic [hvs_pkg::TurnWidth-1:0]          turn,
   output logic                                   out_valid,
   output logic signed [hvs_pkg::CoordWidth-1:0]  new_x,
   output logic signed [hvs_pkg::CoordWidth-1:0]  new_y
);
   localparam int CW = hvs_pkg::CoordWidth;
   localparam int DW = hvs_pkg::DiffWidth;
   localparam int PW = hvs_pkg::ProdWidth;
   localparam int SW = hvs_pkg::SumWidth;
   localparam int QW = hvs_pkg::QuoWidth;
   localparam logic signed [SW-1:0] SatHi = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] SatLo = -SW'(64'sd1 <<< (CW - 1));

   logic [2:0] valid_ff;
   logic signed [QW:0] wx, wy;
   logic signed [DW-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic signed [PW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [hvs_pkg::TurnWidth:0] turn_s;
   logic signed [CW-1:0] va_x_ff, va_y_ff, vb_x_ff, vb_y_ff, ox_ff, oy_ff;
   logic signed [SW-1:0] rx, ry;
   logic signed [CW-1:0] ox_in, oy_in;

   always_comb begin
      wx = dist_zero ? '0 : (carry.sx ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x}));
      wy = dist_zero ? '0 : (carry.sy ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y}));
      ex_in = DW'(wx) - DW'(carry.vx);
      ey_in = DW'(wy) - DW'(carry.vy);
      turn_s = $signed({1'b0, turn});
      px_in = PW'(ex_ff) * PW'(turn_s);
      py_in = PW'(ey_ff) * PW'(turn_s);
      // arithmetic shift floors toward minus infinity
      rx = SW'(vb_x_ff) + SW'(px_ff >>> hvs_pkg::TurnShift);
      ry = SW'(vb_y_ff) + SW'(py_ff >>> hvs_pkg::TurnShift);
      priority if (rx > SatHi) ox_in = SatHi[CW-1:0];
      else if (rx < SatLo)     ox_in = SatLo[CW-1:0];
      else                     ox_in = rx[CW-1:0];
      priority if (ry > SatHi) oy_in = SatHi[CW-1:0];
      else if (ry < SatLo)     oy_in = SatLo[CW-1:0];
      else                     oy_in = ry[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
      if (advance) begin
         ex_ff   <= ex_in;
         ey_ff   <= ey_in;
         va_x_ff <= carry.vx;
         va_y_ff <= carry.vy;
         px_ff   <= px_in;
         py_ff   <= py_in;
         vb_x_ff <= va_x_ff;
         vb_y_ff <= va_y_ff;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign new_x     = ox_ff;
   assign new_y     = oy_ff;
endmodule
